// ----- src/ray_sphere_intersect_core_defines.svh -----
// assertion macros for the ray sphere intersection core
// used by ray_sphere_intersect_core; expects clk_i and rst_ni in scope
`ifndef RAY_SPHERE_INTERSECT_CORE_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_CORE_DEFINES_SVH

// condition now implies check now
`define RSI_ASSERT_NOW(lbl, cond, chk, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (chk)) \
    else $error(msg);

// condition now implies check in the next cycle
`define RSI_ASSERT_NEXT(lbl, cond, chk, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (chk)) \
    else $error(msg);

`endif

// ----- src/rsi_pkg.sv -----
// types, constants and square root step for the ray sphere intersection core
// no dependencies
package rsi_pkg;

  localparam int unsigned DIR_FRAC   = 16;
  localparam int unsigned RAD_W      = 76;
  localparam int unsigned ROOT_W     = 38;
  localparam int unsigned REM_W      = 41;
  localparam int unsigned SQ_STAGES  = ROOT_W / 2;

  typedef enum logic [2:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_RADIUS_SQ = 3'd3,
    CFG_EPSILON  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_t;

  // two digit-by-digit square root iterations
  function automatic sq_t sqrt_step(sq_t s);
    sq_t r;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    r = s;
    for (int k = 0; k < 2; k++) begin
      rem2  = {r.rem[REM_W-3:0], r.rad[RAD_W-1 -: 2]};
      trial = {{(REM_W-ROOT_W-2){1'b0}}, r.root, 2'b01};
      r.rad = {r.rad[RAD_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        r.rem  = rem2 - trial;
        r.root = {r.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.rem  = rem2;
        r.root = {r.root[ROOT_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ----- src/ray_sphere_intersect_core.sv -----
// ray sphere intersection core, fully pipelined, one ray per cycle while the result channel is not stalled
// depends on rsi_pkg and ray_sphere_intersect_core_defines.svh
//
//   channel  handshake                 payload
//   cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//   ray in   in_valid_i / in_ready_o   origin_*_i, dir_*_i
//   result   out_valid_o / out_ready_i hit_o, distance_o, entering_o
//
// one word per cycle while not stalled; 5 arithmetic stages, 19 square root
// stages (two root bits each), and the output register
// every stage advances together when the output register is empty or taken
// reset clears all valid bits; config registers return to their reset values
`include "ray_sphere_intersect_core_defines.svh"

module ray_sphere_intersect_core #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  rsi_pkg::cfg_idx_e    cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   origin_x_i,
  input  logic signed [31:0]   origin_y_i,
  input  logic signed [31:0]   origin_z_i,
  input  logic signed [17:0]   dir_x_i,
  input  logic signed [17:0]   dir_y_i,
  input  logic signed [17:0]   dir_z_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic [31:0]          distance_o,
  output logic                 entering_o
);
  import rsi_pkg::*;

  localparam int unsigned NV = SQ_STAGES + 6;

  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [63:0]        r2_q;
  logic [15:0]        eps_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      r2_q  <= 64'h1_0000_0000;
      eps_q <= 16'd66;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CENTER_X:  cx_q  <= cfg_data_i[31:0];
        CFG_CENTER_Y:  cy_q  <= cfg_data_i[31:0];
        CFG_CENTER_Z:  cz_q  <= cfg_data_i[31:0];
        CFG_RADIUS_SQ: r2_q  <= cfg_data_i;
        CFG_EPSILON:   eps_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic          en;
  logic [NV-1:0] vld_q;

  assign en          = !vld_q[NV-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  // stage 1: center minus origin
  logic signed [32:0] vx_q, vy_q, vz_q;
  logic signed [17:0] dx_q, dy_q, dz_q;
  // stage 2: products
  logic signed [50:0] px_q, py_q, pz_q;
  logic [65:0]        sx_q, sy_q, sz_q;
  // stage 3: sums
  logic signed [36:0] b3_q;
  logic [67:0]        vv3_q;
  // stage 4: b squared, entering
  logic signed [36:0] b4_q;
  logic [67:0]        vv4_q;
  logic [73:0]        b2_q;
  logic               ent4_q;
  // square root pipeline, index 0 loaded by stage 5
  sq_t                sq_q  [0:SQ_STAGES];
  logic signed [36:0] sb_q  [0:SQ_STAGES];
  logic               sn_q  [0:SQ_STAGES];
  logic               se_q  [0:SQ_STAGES];

  logic signed [65:0] sqx, sqy, sqz;
  logic signed [52:0] braw;
  logic [36:0]        bmag;
  logic [67:0]        lim;
  logic [74:0]        a5;
  logic [74:0]        disc;

  assign sqx  = vx_q * vx_q;
  assign sqy  = vy_q * vy_q;
  assign sqz  = vz_q * vz_q;
  assign braw = 53'(px_q) + 53'(py_q) + 53'(pz_q);
  assign bmag = b3_q[36] ? 37'(-b3_q) : 37'(b3_q);
  assign lim  = {4'b0, r2_q} + (68'(eps_q) << COORD_FRAC_BITS);
  assign a5   = 75'(b2_q) + 75'(r2_q);
  assign disc = a5 - 75'(vv4_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q  <= 33'(cx_q) - 33'(origin_x_i);
      vy_q  <= 33'(cy_q) - 33'(origin_y_i);
      vz_q  <= 33'(cz_q) - 33'(origin_z_i);
      dx_q  <= dir_x_i;
      dy_q  <= dir_y_i;
      dz_q  <= dir_z_i;
      px_q  <= vx_q * dx_q;
      py_q  <= vy_q * dy_q;
      pz_q  <= vz_q * dz_q;
      sx_q  <= $unsigned(sqx);
      sy_q  <= $unsigned(sqy);
      sz_q  <= $unsigned(sqz);
      b3_q  <= braw[52:DIR_FRAC];
      vv3_q <= 68'(sx_q) + 68'(sy_q) + 68'(sz_q);
      b4_q  <= b3_q;
      vv4_q <= vv3_q;
      b2_q  <= bmag * bmag;
      ent4_q <= lim < vv3_q;
      sq_q[0] <= '{rem: '0, root: '0, rad: {1'b0, disc}};
      sb_q[0] <= b4_q;
      sn_q[0] <= a5 < 75'(vv4_q);
      se_q[0] <= ent4_q;
    end
  end

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[g+1] <= sqrt_step(sq_q[g]);
        sb_q[g+1] <= sb_q[g];
        sn_q[g+1] <= sn_q[g];
        se_q[g+1] <= se_q[g];
      end
    end
  end

  // root selection
  logic signed [39:0] bx, sx, ex, t0, t1, tsel;
  logic               ok0, ok1, hit;
  logic [31:0]        dist_sel;

  assign bx   = 40'(sb_q[SQ_STAGES]);
  assign sx   = $signed({2'b00, sq_q[SQ_STAGES].root});
  assign ex   = $signed({24'd0, eps_q});
  assign t0   = bx - sx;
  assign t1   = bx + sx;
  assign ok0  = t0 > ex;
  assign ok1  = t1 > ex;
  assign hit  = !sn_q[SQ_STAGES] && (ok0 || ok1);
  assign tsel = ok0 ? t0 : t1;
  assign dist_sel = !hit ? 32'd0 : (|tsel[39:32]) ? 32'hFFFF_FFFF : tsel[31:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_o      <= hit;
      distance_o <= dist_sel;
      entering_o <= se_q[SQ_STAGES];
    end
  end

  `RSI_ASSERT_NOW(a_ready_tracks_output, 1'b1, in_ready_o == (!out_valid_o || out_ready_i),
    "input ready does not follow output register state")
  `RSI_ASSERT_NOW(a_miss_zero, out_valid_o && !hit_o, distance_o == 32'd0,
    "miss word carries nonzero distance")
  `RSI_ASSERT_NOW(a_hit_beyond_eps, out_valid_o && hit_o, distance_o > 32'(eps_q),
    "hit distance not beyond epsilon")
  `RSI_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i,
    out_valid_o && $stable(distance_o) && $stable(hit_o) && $stable(entering_o),
    "stalled result word changed")

endmodule
